>>> src/crq_pkg.sv
// ============================================================================
// crq_pkg - circular ring queue shared definitions
// Widths, opcodes and the control bundle that drives the row of storage cells.
// ============================================================================
`default_nettype none

package crq_pkg;

  localparam int unsigned Depth    = 1024;
  localparam int unsigned WordBits = 32;
  localparam int unsigned OutBits  = 32;
  localparam int unsigned OpBits   = 2;
  localparam int unsigned CntBits  = $clog2(Depth + 1);
  localparam int unsigned IdxBits  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CapReset = (1024 > Depth) ? Depth : 1024;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic        [CntBits-1:0]  cnt_t;
  typedef logic        [IdxBits-1:0]  idx_t;

  typedef enum logic [OpBits-1:0] {
    OpEnqueue = 2'd0,
    OpDequeue = 2'd1,
    OpQuery   = 2'd2
  } op_e;

  typedef struct packed {
    logic  shift;
    logic  load;
    idx_t  load_pos;
    word_t load_word;
  } chain_ctrl_t;

  function automatic cnt_t clamp_capacity(input cnt_t v);
    cnt_t c;
    c = v;
    if (c == '0) begin
      c = cnt_t'(1);
    end
    if (c > cnt_t'(Depth)) begin
      c = cnt_t'(Depth);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/crq_cell.sv
// ============================================================================
// crq_cell - one storage cell of the queue row
// Loads a new word on enqueue, or takes its neighbor's word on dequeue.
// ============================================================================
`default_nettype none

module crq_cell (
  input  wire             clk_i,
  input  wire             shift_i,
  input  wire             load_i,
  input  crq_pkg::word_t  load_word_i,
  input  crq_pkg::word_t  next_word_i,
  output crq_pkg::word_t  word_o
);

  crq_pkg::word_t word_q;
  crq_pkg::word_t word_d;

  always_comb begin
    word_d = word_q;
    if (load_i) begin
      word_d = load_word_i;
    end else if (shift_i) begin
      word_d = next_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

>>> src/crq_chain.sv
// ============================================================================
// crq_chain - row of queue cells
// Cell 0 holds the oldest word; dequeue moves every word one cell forward.
// ============================================================================
`default_nettype none

module crq_chain (
  input  wire                  clk_i,
  input  crq_pkg::chain_ctrl_t ctrl_i,
  output crq_pkg::word_t       head_word_o,
  output crq_pkg::word_t       next_word_o
);

  crq_pkg::word_t chain_words [crq_pkg::Depth+1];

  assign chain_words[crq_pkg::Depth] = '0;

  for (genvar i = 0; i < crq_pkg::Depth; i++) begin : g_cell
    logic load;
    assign load = ctrl_i.load && (ctrl_i.load_pos == crq_pkg::idx_t'(i));

    crq_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (ctrl_i.shift),
      .load_i      (load),
      .load_word_i (ctrl_i.load_word),
      .next_word_i (chain_words[i+1]),
      .word_o      (chain_words[i])
    );
  end

  assign head_word_o = chain_words[0];
  assign next_word_o = chain_words[1];

endmodule

`default_nettype wire

>>> src/circular_ring_queue_unit.sv
// ============================================================================
// circular_ring_queue_unit - programmable-capacity FIFO of signed words
// Enqueue / dequeue / query per request, one status result per request.
// ============================================================================
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  in      | in_valid_i / in_ready_o    | opcode_i, data_word_i
//  out     | out_valid_o / out_ready_i  | accepted_o, head_word_o, tail_word_o,
//          |                            | empty_flag_o, full_flag_o
//  cfg     | cfg_we_i                   | cfg_wdata_i (capacity)
//
//  One request per cycle; its result is registered and shows the next cycle.
//  The row of cells shifts on dequeue, so the oldest word is always in cell 0.
//  A new request is taken while the output register is empty or being drained.
//  Reset empties the queue and sets the capacity to its full depth.
//  Capacity writes take effect only while the queue holds no entries.
// ============================================================================
`default_nettype none

module circular_ring_queue_unit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  [crq_pkg::OpBits-1:0]         opcode_i,
  input  wire  signed [crq_pkg::WordBits-1:0] data_word_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic                               accepted_o,
  output logic signed [crq_pkg::OutBits-1:0] head_word_o,
  output logic signed [crq_pkg::OutBits-1:0] tail_word_o,
  output logic                               empty_flag_o,
  output logic                               full_flag_o,
  input  wire                                cfg_we_i,
  input  wire  [crq_pkg::CntBits-1:0]        cfg_wdata_i
);

  crq_pkg::cnt_t        cnt_q, cnt_d;
  crq_pkg::cnt_t        cap_q;
  crq_pkg::word_t       tail_q, tail_d;
  crq_pkg::word_t       head_d;
  crq_pkg::word_t       head_cell, next_cell;
  crq_pkg::op_e         op;
  crq_pkg::chain_ctrl_t ctrl;
  logic                 take, ok, do_enq, do_deq;
  logic                 out_valid_q;
  logic                 acc_q, empty_q, full_q;
  crq_pkg::word_t       head_out_q, tail_out_q;

  assign op         = crq_pkg::op_e'(opcode_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    ok     = 1'b0;
    do_enq = 1'b0;
    do_deq = 1'b0;
    case (op)
      crq_pkg::OpEnqueue: begin
        ok     = cnt_q < cap_q;
        do_enq = ok;
      end
      crq_pkg::OpDequeue: begin
        ok     = cnt_q != '0;
        do_deq = ok;
      end
      crq_pkg::OpQuery: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    tail_d = tail_q;
    head_d = head_cell;
    if (do_enq) begin
      cnt_d  = cnt_q + crq_pkg::cnt_t'(1);
      tail_d = data_word_i;
      if (cnt_q == '0) begin
        head_d = data_word_i;
      end
    end else if (do_deq) begin
      cnt_d  = cnt_q - crq_pkg::cnt_t'(1);
      head_d = next_cell;
    end
  end

  assign ctrl.shift     = take && do_deq;
  assign ctrl.load      = take && do_enq;
  assign ctrl.load_pos  = cnt_q[crq_pkg::IdxBits-1:0];
  assign ctrl.load_word = data_word_i;

  crq_chain u_chain (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .head_word_o (head_cell),
    .next_word_o (next_cell)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cap_q       <= crq_pkg::cnt_t'(crq_pkg::CapReset);
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        cnt_q <= cnt_d;
      end
      if (cfg_we_i && (cnt_q == '0)) begin
        cap_q <= crq_pkg::clamp_capacity(cfg_wdata_i);
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tail_q     <= tail_d;
      acc_q      <= ok;
      empty_q    <= cnt_d == '0;
      full_q     <= cnt_d == cap_q;
      head_out_q <= (cnt_d == '0) ? '1 : head_d;
      tail_out_q <= (cnt_d == '0) ? '1 : tail_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = acc_q;
  assign head_word_o  = head_out_q;
  assign tail_word_o  = tail_out_q;
  assign empty_flag_o = empty_q;
  assign full_flag_o  = full_q;

endmodule

`default_nettype wire

>>> src/crq_checker.sv
// ============================================================================
// crq_checker - port-level checks for the ring queue
// Watches handshakes and result consistency on the top-level ports.
// ============================================================================
`default_nettype none

module crq_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                in_valid_i,
  input wire                                in_ready_o,
  input wire                                out_valid_o,
  input wire                                out_ready_i,
  input wire                                accepted_o,
  input wire signed [crq_pkg::OutBits-1:0]  head_word_o,
  input wire signed [crq_pkg::OutBits-1:0]  tail_word_o,
  input wire                                empty_flag_o,
  input wire                                full_flag_o
);

  // stall only while a result is pending
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_request_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("accepted request produced no result");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(head_word_o) && $stable(tail_word_o)
       && $stable(accepted_o)))
    else $error("stalled result changed");

  a_empty_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_flag_o) |-> (head_word_o == '1 && tail_word_o == '1))
    else $error("empty queue reports stored words");

  a_not_empty_and_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(empty_flag_o && full_flag_o))
    else $error("queue reports empty and full together");

endmodule

bind circular_ring_queue_unit crq_checker u_crq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .accepted_o   (accepted_o),
  .head_word_o  (head_word_o),
  .tail_word_o  (tail_word_o),
  .empty_flag_o (empty_flag_o),
  .full_flag_o  (full_flag_o)
);

`default_nettype wire

>>> tb/sv/crq_status_checker.sv
// ============================================================================
// crq_status_checker - status predictor and comparator for the ring queue
// Watches the request, result and capacity ports, keeps its own copy of the
// queue and flags every result that differs from the predicted status.
// ============================================================================
`timescale 1ns / 100ps

module crq_status_checker (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  input  wire                                 in_ready_i,
  input  wire  [crq_pkg::OpBits-1:0]          opcode_i,
  input  wire  signed [crq_pkg::WordBits-1:0] data_word_i,
  input  wire                                 out_valid_i,
  input  wire                                 out_ready_i,
  input  wire                                 accepted_i,
  input  wire  signed [crq_pkg::OutBits-1:0]  head_word_i,
  input  wire  signed [crq_pkg::OutBits-1:0]  tail_word_i,
  input  wire                                 empty_flag_i,
  input  wire                                 full_flag_i,
  input  wire                                 cfg_we_i,
  input  wire  [crq_pkg::CntBits-1:0]         cfg_wdata_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  level_o
);

  typedef struct packed {
    logic           accepted;
    crq_pkg::word_t head_word;
    crq_pkg::word_t tail_word;
    logic           empty_flag;
    logic           full_flag;
  } status_t;

  crq_pkg::word_t held_words [crq_pkg::Depth];
  crq_pkg::idx_t  front_idx;
  crq_pkg::idx_t  rear_idx;
  crq_pkg::cnt_t  held;
  crq_pkg::cnt_t  cap_r;
  status_t        status_q [$];
  int             fails = 0;

  assign fail_count_o = fails;

  function automatic crq_pkg::cnt_t fit_capacity(input crq_pkg::cnt_t v);
    if (v == '0) begin
      return crq_pkg::cnt_t'(1);
    end
    if (int'(v) > int'(crq_pkg::Depth)) begin
      return crq_pkg::cnt_t'(crq_pkg::Depth);
    end
    return v;
  endfunction

  // wrap by compare against capacity
  function automatic crq_pkg::idx_t next_idx(input crq_pkg::idx_t i);
    if (int'(i) + 1 >= int'(cap_r)) begin
      return '0;
    end
    return crq_pkg::idx_t'(int'(i) + 1);
  endfunction

  function automatic status_t apply_request(input logic [crq_pkg::OpBits-1:0] op,
                                            input crq_pkg::word_t w);
    status_t s;
    logic    ok;
    ok = 1'b0;
    case (op)
      crq_pkg::OpEnqueue: begin
        if (held < cap_r) begin
          rear_idx = next_idx(rear_idx);
          held_words[rear_idx] = w;
          held = held + crq_pkg::cnt_t'(1);
          ok = 1'b1;
        end
      end
      crq_pkg::OpDequeue: begin
        if (held != '0) begin
          front_idx = next_idx(front_idx);
          held = held - crq_pkg::cnt_t'(1);
          ok = 1'b1;
        end
      end
      crq_pkg::OpQuery: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    s.accepted = ok;
    if (held == '0) begin
      s.head_word = '1;
      s.tail_word = '1;
    end else begin
      s.head_word = held_words[front_idx];
      s.tail_word = held_words[rear_idx];
    end
    s.empty_flag = (held == '0);
    s.full_flag  = (held == cap_r);
    return s;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%08h, actual 'h%08h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    status_t want;
    if (!rst_ni) begin
      cap_r     = crq_pkg::cnt_t'(crq_pkg::CapReset);
      front_idx = '0;
      rear_idx  = crq_pkg::idx_t'(cap_r - crq_pkg::cnt_t'(1));
      held      = '0;
      status_q.delete();
      pending_o <= 0;
      level_o   <= 0;
    end else begin
      // result of an earlier request; check before this edge's request
      if (out_valid_i && out_ready_i) begin
        if (status_q.size() == 0) begin
          $error("result with no request waiting");
          fails++;
        end else begin
          want = status_q.pop_front();
          compare_field("accepted", 32'(want.accepted), 32'(accepted_i));
          compare_field("head_word", want.head_word, head_word_i);
          compare_field("tail_word", want.tail_word, tail_word_i);
          compare_field("empty_flag", 32'(want.empty_flag), 32'(empty_flag_i));
          compare_field("full_flag", 32'(want.full_flag), 32'(full_flag_i));
        end
      end
      // capacity write is dropped while entries are held
      if (cfg_we_i && held == '0) begin
        cap_r     = fit_capacity(cfg_wdata_i);
        front_idx = '0;
        rear_idx  = crq_pkg::idx_t'(cap_r - crq_pkg::cnt_t'(1));
      end
      if (in_valid_i && in_ready_i) begin
        status_q.push_back(apply_request(opcode_i, data_word_i));
      end
      pending_o <= status_q.size();
      level_o   <= int'(held);
    end
  end

endmodule

>>> tb/sv/tb_circular_ring_queue_unit.sv
// ============================================================================
// tb_circular_ring_queue_unit - ring queue testbench top
// Drives directed and random request streams over several capacities with
// random idling on both channels; the status checker predicts and compares.
// ============================================================================
`timescale 1ns / 100ps

module tb_circular_ring_queue_unit;

  localparam logic [crq_pkg::OpBits-1:0] OpReserved = 2'd3;
  localparam int StallLimit = 2000;
  localparam int FillCap = 40;

  logic                         clk_i = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic [crq_pkg::OpBits-1:0]   opcode = crq_pkg::OpQuery;
  crq_pkg::word_t               data_word = '0;
  logic                         out_ready = 1'b0;
  logic                         cfg_we = 1'b0;
  crq_pkg::cnt_t                cfg_wdata = '0;

  wire                          in_ready;
  wire                          out_valid;
  wire                          accepted;
  wire  signed [crq_pkg::OutBits-1:0] head_word;
  wire  signed [crq_pkg::OutBits-1:0] tail_word;
  wire                          empty_flag;
  wire                          full_flag;

  int                           fail_count;
  int                           pending;
  int                           level;
  int                           in_idle_pct = 11;
  int                           out_idle_pct = 66;
  int                           stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  circular_ring_queue_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .opcode_i     (opcode),
    .data_word_i  (data_word),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .accepted_o   (accepted),
    .head_word_o  (head_word),
    .tail_word_o  (tail_word),
    .empty_flag_o (empty_flag),
    .full_flag_o  (full_flag),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  crq_status_checker status_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .opcode_i     (opcode),
    .data_word_i  (data_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .accepted_i   (accepted),
    .head_word_i  (head_word),
    .tail_word_i  (tail_word),
    .empty_flag_i (empty_flag),
    .full_flag_i  (full_flag),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .level_o      (level)
  );

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("** circular_ring_queue_unit: FAILED **");
        $finish;
      end
    end
  end

  function automatic crq_pkg::word_t rand_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_request(input logic [crq_pkg::OpBits-1:0] op,
                              input crq_pkg::word_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_word <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // hold off requests until every status has been returned
  task automatic await_all_status();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_capacity(input crq_pkg::cnt_t v);
    await_all_status();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic empty_queue();
    int n;
    await_all_status();
    n = level;
    repeat (n) send_request(crq_pkg::OpDequeue, rand_word());
    await_all_status();
  endtask

  task automatic run_random(input int n_items, input int cap_val);
    int                         eff;
    int                         span;
    int                         len;
    int                         r;
    bit                         fill;
    logic [crq_pkg::OpBits-1:0] op;
    empty_queue();
    set_capacity(crq_pkg::cnt_t'(cap_val));
    eff  = (cap_val == 0) ? 1 :
           ((cap_val > int'(crq_pkg::Depth)) ? int'(crq_pkg::Depth) : cap_val);
    span = (eff > 30) ? 60 : 2 * eff + 2;
    fill = 1'b1;
    while (n_items > 0) begin
      len = $urandom_range(span, 1);
      repeat (len) begin
        r = $urandom_range(99);
        if (r < 70) op = fill ? crq_pkg::OpEnqueue : crq_pkg::OpDequeue;
        else if (r < 88) op = fill ? crq_pkg::OpDequeue : crq_pkg::OpEnqueue;
        else if (r < 97) op = crq_pkg::OpQuery;
        else op = OpReserved;
        send_request(op, rand_word());
      end
      n_items -= len;
      fill = !fill;
      if ($urandom_range(24) == 0) await_all_status();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;

    // directed: empty queue, refusals, word extremes, reserved opcode
    send_request(crq_pkg::OpQuery, '0);
    send_request(crq_pkg::OpDequeue, '0);
    send_request(OpReserved, 32'h1234_5678);
    send_request(crq_pkg::OpEnqueue, 32'h8000_0000);
    send_request(crq_pkg::OpEnqueue, 32'h7FFF_FFFF);
    send_request(crq_pkg::OpEnqueue, '0);
    send_request(crq_pkg::OpEnqueue, '1);
    send_request(OpReserved, 32'h0F0F_0F0F);
    send_request(crq_pkg::OpQuery, '1);
    set_capacity(crq_pkg::cnt_t'(5));  // ignored, entries held
    repeat (5) send_request(crq_pkg::OpDequeue, '1);
    set_capacity('0);         // acts as one entry
    send_request(crq_pkg::OpEnqueue, 32'h5555_5555);
    send_request(crq_pkg::OpEnqueue, 32'h1111_1111);
    send_request(crq_pkg::OpQuery, '0);
    send_request(crq_pkg::OpDequeue, '0);
    send_request(crq_pkg::OpEnqueue, 32'hAAAA_AAAA);
    send_request(crq_pkg::OpDequeue, '0);
    set_capacity('1);         // above depth
    send_request(crq_pkg::OpEnqueue, 32'h0000_0001);
    send_request(crq_pkg::OpDequeue, '0);

    // sender idles rarely, receiver often
    run_random(70, 3);
    run_random(60, 0);
    run_random(60, 8);

    // sender idles often, receiver rarely
    in_idle_pct = 66;
    out_idle_pct <= 11;
    run_random(70, 2);
    run_random(60, 17);
    run_random(60, $urandom_range(40, 1));

    // no idling
    in_idle_pct = 0;
    out_idle_pct <= 0;
    run_random(40, int'(crq_pkg::Depth));
    // fill to capacity, one refused enqueue, drain past empty
    empty_queue();
    set_capacity(crq_pkg::cnt_t'(FillCap));
    repeat (FillCap) send_request(crq_pkg::OpEnqueue, rand_word());
    send_request(crq_pkg::OpEnqueue, rand_word());
    send_request(crq_pkg::OpQuery, '0);
    repeat (FillCap + 1) send_request(crq_pkg::OpDequeue, rand_word());
    run_random(60, 1);
    run_random(80, 6);

    await_all_status();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** circular_ring_queue_unit: PASSED **");
    end else begin
      $display("** circular_ring_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule
